### sv/cdtm_pkg.sv
// cdtm_pkg: types and constants shared by the clock domain tag min/max table
// holds the transfer structs, the token that walks the cell chain and the mode codes
// no dependencies
package cdtm_pkg;

    localparam int MAX_TAGS    = 16;
    localparam int DOMAIN_BITS = 8;
    localparam int NODE_BITS   = 20;
    localparam int TIME_BITS   = 32;
    localparam int COUNT_W     = $clog2(MAX_TAGS + 1);
    localparam int MODE_W      = 3;

    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAX    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIN    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]           mode;
        logic [DOMAIN_BITS-1:0]      domain;
        logic                        domain_valid;
        logic signed [TIME_BITS-1:0] arrival_time;
        logic [NODE_BITS-1:0]        launch_id;
    } in_item_t;

    typedef struct packed {
        logic                        found;
        logic signed [TIME_BITS-1:0] entry_time;
        logic [NODE_BITS-1:0]        entry_launch;
        logic                        entry_changed;
        logic [COUNT_W-1:0]          tag_count;
        logic                        overflow;
    } out_item_t;

    // request travelling down the chain, one cell per cycle
    typedef struct packed {
        logic                        valid;
        in_item_t                    req;
        logic [COUNT_W-1:0]          cnt;      // table count when the request entered
        logic [COUNT_W-1:0]          left;     // occupied cells still ahead
        logic                        matched;
        logic                        appended;
        logic                        changed;
        logic signed [TIME_BITS-1:0] etime;
        logic [NODE_BITS-1:0]        enode;
    } token_t;

endpackage

### sv/clock_domain_tag_minmax_table_unit.sv
// clock_domain_tag_minmax_table_unit: top level of the clock domain tag min/max table
// depends on cdtm_pkg and cdtm_cell
//
// Usage
//   s_valid/s_ready/s_data carry requests (add, max merge, min merge, clear,
//   lookup); m_valid/m_ready/m_data carry exactly one result per request.
//   The table is a row of MAX_TAGS cells, each holding one tag. A request is
//   registered, then walks the row one cell per cycle: occupied cells compare
//   the domain and, for a max or min merge, apply it at the first match; the
//   first free cell takes an append. The path from the input transfer to
//   m_valid runs through the head register, every cell of the row and the
//   output register. One request is in the row at a time, so a new request
//   is not taken until the previous one has left the row.
//   A finished result waits in the output register while the next request
//   walks the row; if that next result is done before the first is taken, it
//   parks in a one-entry holding register and s_ready stays low until the
//   first result is taken and the held one moves to the output register.
//   Reset empties the table (count zero) and drops any request in flight;
//   tag contents are not cleared and are never read before being written.
module clock_domain_tag_minmax_table_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cdtm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cdtm_pkg::out_item_t m_data
);
    import cdtm_pkg::*;

    logic               busy_reg, busy_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    out_item_t          pend_reg, pend_next;
    out_item_t          m_data_reg, m_data_next;
    token_t             head_reg, head_next;
    token_t             chain [MAX_TAGS+1];
    out_item_t          res;
    logic               in_xfer, out_free;

    assign chain[0] = head_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TAGS; gi++) begin : g_cell
            cdtm_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_i   (chain[gi]),
                .tok_o   (chain[gi+1])
            );
        end
    endgenerate

    always_comb begin
        token_t t;
        t = chain[MAX_TAGS];
        res.found         = t.matched;
        res.entry_time    = t.etime;
        res.entry_launch  = t.enode;
        res.entry_changed = t.changed;
        res.overflow      = t.req.domain_valid && !t.appended &&
                            ((t.req.mode == MODE_ADD) ||
                             ((t.req.mode == MODE_MAX || t.req.mode == MODE_MIN) &&
                              !t.matched));
        if (t.req.mode == MODE_CLEAR) begin
            res.tag_count = '0;
        end else begin
            res.tag_count = t.cnt + COUNT_W'(t.appended);
        end
    end

    assign s_ready  = !busy_reg && !pend_valid_reg;
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        head_next          = '0;
        head_next.valid    = in_xfer;
        head_next.req      = s_data;
        head_next.cnt      = cnt_reg;
        head_next.left     = cnt_reg;

        busy_next       = busy_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (in_xfer) begin
            busy_next = 1'b1;
        end
        if (chain[MAX_TAGS].valid) begin
            busy_next = 1'b0;
            cnt_next  = res.tag_count;
        end

        if (out_free) begin
            if (pend_valid_reg) begin
                m_data_next     = pend_reg;
                m_valid_next    = 1'b1;
                pend_valid_next = 1'b0;
            end else if (chain[MAX_TAGS].valid) begin
                m_data_next  = res;
                m_valid_next = 1'b1;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (chain[MAX_TAGS].valid) begin
            pend_next       = res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
            head_reg.valid <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            cnt_reg        <= cnt_next;
            head_reg.valid <= head_next.valid;
        end
        head_reg.req      <= head_next.req;
        head_reg.cnt      <= head_next.cnt;
        head_reg.left     <= head_next.left;
        head_reg.matched  <= head_next.matched;
        head_reg.appended <= head_next.appended;
        head_reg.changed  <= head_next.changed;
        head_reg.etime    <= head_next.etime;
        head_reg.enode    <= head_next.enode;
        pend_reg          <= pend_next;
        m_data_reg        <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### sv/cdtm_cell.sv
// cdtm_cell: one table entry plus one stage of the request chain
// depends on cdtm_pkg
module cdtm_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  cdtm_pkg::token_t tok_i,
    output cdtm_pkg::token_t tok_o
);
    import cdtm_pkg::*;

    logic [DOMAIN_BITS-1:0]      dom_reg;
    logic signed [TIME_BITS-1:0] time_reg;
    logic [NODE_BITS-1:0]        node_reg;
    token_t                      tok_reg;
    token_t                      tok_next;

    logic live, occupied, hit, better, wants_append, place;

    always_comb begin
        live = tok_i.valid && tok_i.req.domain_valid &&
               (tok_i.req.mode == MODE_ADD || tok_i.req.mode == MODE_MAX ||
                tok_i.req.mode == MODE_MIN || tok_i.req.mode == MODE_LOOKUP);
        occupied = (tok_i.left != '0);
        hit = live && occupied && !tok_i.matched && (dom_reg == tok_i.req.domain);
        better = 1'b0;
        if (tok_i.req.mode == MODE_MAX) begin
            better = tok_i.req.arrival_time > time_reg;
        end else if (tok_i.req.mode == MODE_MIN) begin
            better = tok_i.req.arrival_time < time_reg;
        end
        wants_append = (tok_i.req.mode == MODE_ADD) ||
                       ((tok_i.req.mode == MODE_MAX || tok_i.req.mode == MODE_MIN) &&
                        !tok_i.matched);
        // first free cell takes the append
        place = live && !occupied && !tok_i.appended && wants_append;

        tok_next = tok_i;
        if (occupied) begin
            tok_next.left = tok_i.left - COUNT_W'(1);
        end
        if (hit) begin
            tok_next.matched = 1'b1;
            if (better) begin
                tok_next.etime   = tok_i.req.arrival_time;
                tok_next.enode   = tok_i.req.launch_id;
                tok_next.changed = 1'b1;
            end else begin
                tok_next.etime = time_reg;
                tok_next.enode = node_reg;
            end
        end
        if (place) begin
            tok_next.appended = 1'b1;
            tok_next.changed  = 1'b1;
            tok_next.etime    = tok_i.req.arrival_time;
            tok_next.enode    = tok_i.req.launch_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.req      <= tok_next.req;
        tok_reg.cnt      <= tok_next.cnt;
        tok_reg.left     <= tok_next.left;
        tok_reg.matched  <= tok_next.matched;
        tok_reg.appended <= tok_next.appended;
        tok_reg.changed  <= tok_next.changed;
        tok_reg.etime    <= tok_next.etime;
        tok_reg.enode    <= tok_next.enode;
        if (place) begin
            dom_reg <= tok_i.req.domain;
        end
        if ((hit && better) || place) begin
            time_reg <= tok_i.req.arrival_time;
            node_reg <= tok_i.req.launch_id;
        end
    end

    assign tok_o = tok_reg;

endmodule
